### rtl/core/tcfsd_pkg.sv
// ----------------------------------------------------------------------------
// tcfsd_pkg
// Shared types and constants for the two-class queue with class dequeue.
// ----------------------------------------------------------------------------
package tcfsd_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_TAG_BITS    = 16;

    localparam int REQ_W    = 2;
    localparam int KIND_W   = 1;
    localparam int PORT_TAG_W = 16;
    localparam int STATUS_W = 2;
    localparam int EXT_TAG_W  = 64;

    localparam int DATA_BITS = KIND_W + PORT_TAG_W;
    localparam int TDATA_W   = ((DATA_BITS + 7) / 8) * 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_ENQ  = 2'd0,
        REQ_ANY  = 2'd1,
        REQ_CLS0 = 2'd2,
        REQ_CLS1 = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ENQUEUED = 2'd0,
        ST_DEQUEUED = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_HOLD = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic exec;
    } ctrl_cmd_t;

endpackage

### rtl/core/tcfsd_ctrl.sv
// ----------------------------------------------------------------------------
// tcfsd_ctrl
// Handshake controller: takes a request, holds the result until taken.
// ----------------------------------------------------------------------------
module tcfsd_ctrl
    import tcfsd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output ctrl_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (m_tready && !s_tvalid)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
            end
            S_HOLD:
            begin
                m_tvalid = 1'b1;
                s_tready = m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
        cmd.exec = s_tvalid && s_tready;
    end

endmodule

### rtl/core/tcfsd_datapath.sv
// ----------------------------------------------------------------------------
// tcfsd_datapath
// Row of queue cells with priority pick, local shift and result register.
// ----------------------------------------------------------------------------
module tcfsd_datapath
    import tcfsd_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int TAG_BITS    = DEF_TAG_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_cmd_t             cmd,
    input  req_t                  req_type,
    input  logic                  animal_kind,
    input  logic [PORT_TAG_W-1:0] name_tag,
    output status_t               status,
    output logic                  out_kind,
    output logic [PORT_TAG_W-1:0] out_tag
);

    logic [QUEUE_DEPTH-1:0] valid_reg;
    logic [QUEUE_DEPTH-1:0] valid_next;
    logic [QUEUE_DEPTH-1:0] kind_reg;
    logic [QUEUE_DEPTH-1:0] kind_next;
    logic [TAG_BITS-1:0]    tag_reg  [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]    tag_next [QUEUE_DEPTH];

    status_t               status_reg;
    status_t               status_next;
    logic                  okind_reg;
    logic                  okind_next;
    logic [PORT_TAG_W-1:0] otag_reg;
    logic [PORT_TAG_W-1:0] otag_next;

    logic [EXT_TAG_W-1:0]   in_ext;
    logic [EXT_TAG_W-1:0]   out_ext;
    logic [TAG_BITS-1:0]    tag_in;
    logic [TAG_BITS-1:0]    sel_tag;
    logic                   sel_kind;
    logic [QUEUE_DEPTH-1:0] class_mask;
    logic [QUEUE_DEPTH-1:0] match;
    logic [QUEUE_DEPTH-1:0] first;
    logic [QUEUE_DEPTH-1:0] ge_mask;
    logic [QUEUE_DEPTH-1:0] free;
    logic                   hit;
    logic                   full;
    logic                   do_enq;
    logic                   do_deq;

    always_comb
    begin
        in_ext = EXT_TAG_W'(name_tag);
        tag_in = in_ext[TAG_BITS-1:0];

        case (req_type)
            REQ_ANY:  class_mask = '1;
            REQ_CLS1: class_mask = kind_reg;
            default:  class_mask = ~kind_reg;
        endcase

        match   = valid_reg & class_mask;
        first   = match & (~match + QUEUE_DEPTH'(1));
        ge_mask = ~(first - QUEUE_DEPTH'(1));
        hit     = |match;
        free    = ~valid_reg & {valid_reg[QUEUE_DEPTH-2:0], 1'b1};
        full    = valid_reg[QUEUE_DEPTH-1];

        sel_kind = 1'b0;
        sel_tag  = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            sel_kind = sel_kind | (first[i] & kind_reg[i]);
            sel_tag  = sel_tag | (tag_reg[i] & {TAG_BITS{first[i]}});
        end
        out_ext = '0;
        out_ext[TAG_BITS-1:0] = sel_tag;

        do_enq = 1'b0;
        do_deq = 1'b0;
        status_next = ST_EMPTY;
        okind_next  = 1'b0;
        otag_next   = '0;
        case (req_type) inside
            REQ_ENQ:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_ENQUEUED;
                    do_enq      = cmd.exec;
                end
            end
            REQ_ANY, REQ_CLS0, REQ_CLS1:
            begin
                if (hit)
                begin
                    status_next = ST_DEQUEUED;
                    okind_next  = sel_kind;
                    otag_next   = out_ext[PORT_TAG_W-1:0];
                    do_deq      = cmd.exec;
                end
            end
            default:
            begin
                status_next = ST_EMPTY;
            end
        endcase

        valid_next = valid_reg;
        kind_next  = kind_reg;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            tag_next[i] = tag_reg[i];
        end

        // shift cells at and above the removed one down by one
        for (int i = 0; i < QUEUE_DEPTH - 1; i++)
        begin
            if (do_deq && ge_mask[i])
            begin
                valid_next[i] = valid_reg[i+1];
                kind_next[i]  = kind_reg[i+1];
                tag_next[i]   = tag_reg[i+1];
            end
        end
        if (do_deq && ge_mask[QUEUE_DEPTH-1])
        begin
            valid_next[QUEUE_DEPTH-1] = 1'b0;
        end

        // append at the first free cell
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (do_enq && free[i])
            begin
                valid_next[i] = 1'b1;
                kind_next[i]  = animal_kind;
                tag_next[i]   = tag_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            tag_reg[i] <= tag_next[i];
        end
        if (cmd.exec)
        begin
            status_reg <= status_next;
            okind_reg  <= okind_next;
            otag_reg   <= otag_next;
        end
    end

    assign status   = status_reg;
    assign out_kind = okind_reg;
    assign out_tag  = otag_reg;

endmodule

### rtl/core/two_class_fifo_selective_dequeue.sv
// ----------------------------------------------------------------------------
// two_class_fifo_selective_dequeue
// Age-ordered two-class queue with enqueue, oldest dequeue and class dequeue.
//
//   channel  | tdata (low bit up)          | tuser
//   ---------+-----------------------------+-----------------
//   s_       | animal_kind, name_tag, pad  | req_type
//   m_       | out_kind, out_tag, pad      | status
//
// One request per cycle while results are taken: a taken request's result
// sits in the output register from the next cycle, and a new request is taken
// in the same cycle the held result is taken. The cell row is registered.
// Reset empties the queue; a stalled result holds and blocks new requests.
// ----------------------------------------------------------------------------
module two_class_fifo_selective_dequeue
    import tcfsd_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int TAG_BITS    = DEF_TAG_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // animal_kind, name_tag, zero pad
    input  logic [REQ_W-1:0]   s_tuser,   // req_type
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // out_kind, out_tag, zero pad
    output logic [STATUS_W-1:0] m_tuser   // status
);

    ctrl_cmd_t             cmd;
    status_t               status;
    logic                  out_kind;
    logic [PORT_TAG_W-1:0] out_tag;

    tcfsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    tcfsd_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .req_type    (req_t'(s_tuser)),
        .animal_kind (s_tdata[0]),
        .name_tag    (s_tdata[PORT_TAG_W:1]),
        .status      (status),
        .out_kind    (out_kind),
        .out_tag     (out_tag)
    );

    assign m_tdata = TDATA_W'({out_tag, out_kind});
    assign m_tuser = status;

endmodule
